// File: hw/rtl/pgsa_pkg.sv
// Shared constants, types and the efficiency table of the grant sizing allocator.
package pgsa_pkg;

	// Pool geometry
	localparam int MAX_PRBS = 128;
	localparam int IDX_W    = $clog2(MAX_PRBS);
	localparam int CNT_W    = $clog2(MAX_PRBS + 1);

	// Field widths
	localparam int CFG_W    = 8;
	localparam int CMD_W    = 2;
	localparam int MCS_W    = 5;
	localparam int REQ_W    = 22;
	localparam int COUNT_W  = 8;
	localparam int START_W  = 7;
	localparam int TBS_W    = 13;

	// Arithmetic widths
	localparam int BITS_W     = 9;
	localparam int BPB_W      = 6;
	localparam int DIVIDEND_W = REQ_W + 1;
	localparam int PROD_W     = BITS_W + COUNT_W;

	// Fixed values
	localparam logic [CFG_W-1:0] RESET_TOTAL_PRBS   = CFG_W'(100);
	localparam logic [REQ_W-1:0] EMPTY_DEMAND_BYTES = REQ_W'(100);
	localparam logic [TBS_W-1:0] TBS_MAX            = TBS_W'(8191);

	// Command codes
	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_CLEAR = 2'd0;
	localparam cmd_t CMD_SIZE  = 2'd1;
	localparam cmd_t CMD_FIXED = 2'd2;

	// Divider request and response
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [BPB_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

	// Bits per block, linearly interpolated between the six anchors
	function automatic logic [BITS_W-1:0] bits_per_block(input logic [MCS_W-1:0] m);
		logic [BITS_W-1:0] b;
		case (m)
			5'd0:    b = 9'd16;
			5'd1:    b = 9'd25;
			5'd2:    b = 9'd35;
			5'd3:    b = 9'd44;
			5'd4:    b = 9'd54;
			5'd5:    b = 9'd64;
			5'd6:    b = 9'd75;
			5'd7:    b = 9'd86;
			5'd8:    b = 9'd97;
			5'd9:    b = 9'd108;
			5'd10:   b = 9'd120;
			5'd11:   b = 9'd131;
			5'd12:   b = 9'd142;
			5'd13:   b = 9'd153;
			5'd14:   b = 9'd164;
			5'd15:   b = 9'd176;
			5'd16:   b = 9'd195;
			5'd17:   b = 9'd214;
			5'd18:   b = 9'd233;
			5'd19:   b = 9'd252;
			5'd20:   b = 9'd272;
			5'd21:   b = 9'd295;
			5'd22:   b = 9'd318;
			5'd23:   b = 9'd341;
			5'd24:   b = 9'd364;
			5'd25:   b = 9'd387;
			5'd26:   b = 9'd410;
			5'd27:   b = 9'd433;
			default: b = 9'd456;
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/pgsa_div.sv
// Restoring serial divider, one quotient bit per cycle.
module pgsa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pgsa_pkg::div_req_t  req,
	output pgsa_pkg::div_rsp_t  rsp
);

	localparam int STEP_W = $clog2(pgsa_pkg::DIVIDEND_W + 1);

	logic [pgsa_pkg::DIVIDEND_W-1:0] work_q;
	logic [pgsa_pkg::BPB_W-1:0]      rem_q;
	logic [pgsa_pkg::BPB_W-1:0]      dsr_q;
	logic [STEP_W-1:0]               step_q;
	logic                            busy_q;
	logic                            done_q;

	logic [pgsa_pkg::BPB_W:0]        trial;
	logic                            fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, work_q[pgsa_pkg::DIVIDEND_W-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
			step_q <= STEP_W'(pgsa_pkg::DIVIDEND_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= pgsa_pkg::BPB_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[pgsa_pkg::BPB_W-1:0];
			end
			work_q <= {work_q[pgsa_pkg::DIVIDEND_W-2:0], fits};
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

endmodule

// File: hw/rtl/prb_grant_sizing_allocator.sv
// Top level: sizes uplink grants and places them first-fit in the block bitmap.
// One command is taken at a time; in_ready stays low while it is worked on. The bitmap
// lives in a 128-entry memory with one write and one registered read per cycle. After
// reset a clearing pass writes every entry free, one per cycle, and in_ready rises once
// that pass ends. An unused code goes straight to the result. A clear runs the same
// clearing pass and then loads the result. A fixed request is checked on its count and,
// if it passes, scanned first-fit and its run marked, as the scan and the marking each
// visit one block per cycle; a request that finds no run is not granted. A sized request
// first runs the serial divide that turns bytes into blocks, one quotient bit per cycle.
// The result sits in an output register, so the next command is taken while the
// previous result waits.
module prb_grant_sizing_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pgsa_pkg::CFG_W-1:0]     cfg_data,
	// commands
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pgsa_pkg::CMD_W-1:0]     command,
	input  logic [pgsa_pkg::MCS_W-1:0]     mcs,
	input  logic [pgsa_pkg::REQ_W-1:0]     demand_bytes,
	input  logic [pgsa_pkg::COUNT_W-1:0]   prb_count,
	// grants
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           granted,
	output logic [pgsa_pkg::START_W-1:0]   run_start,
	output logic [pgsa_pkg::COUNT_W-1:0]   grant_prbs,
	output logic [pgsa_pkg::TBS_W-1:0]     tbs_bytes
);

	localparam int IDX_W   = pgsa_pkg::IDX_W;
	localparam int CNT_W   = pgsa_pkg::CNT_W;
	localparam int COUNT_W = pgsa_pkg::COUNT_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_CHECK,
		ST_SCAN,
		ST_MARK,
		ST_MUL,
		ST_TBS,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [pgsa_pkg::CFG_W-1:0]     total_q;
	logic                           clr_reply_q;
	logic [pgsa_pkg::BITS_W-1:0]    bits_q;
	logic [COUNT_W-1:0]             n_q;
	logic [COUNT_W-1:0]             run_q;
	logic [CNT_W-1:0]               idx_q;
	logic [IDX_W-1:0]               start_q;
	logic [pgsa_pkg::PROD_W-1:0]    prod_s1;

	logic                           busy_mem [pgsa_pkg::MAX_PRBS];
	logic                           busy_rd_q;

	logic                           res_granted_q;
	logic [pgsa_pkg::START_W-1:0]   res_start_q;
	logic [COUNT_W-1:0]             res_count_q;
	logic [pgsa_pkg::TBS_W-1:0]     res_tbs_q;

	logic                           out_valid_q;
	logic                           granted_q;
	logic [pgsa_pkg::START_W-1:0]   run_start_q;
	logic [COUNT_W-1:0]             grant_prbs_q;
	logic [pgsa_pkg::TBS_W-1:0]     tbs_bytes_q;

	logic                           in_beat;
	logic                           load_out;
	logic [CNT_W-1:0]               pool;
	logic [pgsa_pkg::BITS_W-1:0]    in_bits;
	logic [pgsa_pkg::BPB_W-1:0]     in_bpb;
	logic [pgsa_pkg::REQ_W-1:0]     demand;
	logic [CNT_W-1:0]               scan_start;
	logic [pgsa_pkg::PROD_W-4:0]    tbs_full;
	logic                           mem_we;
	logic                           mem_wdata;
	logic [IDX_W-1:0]               mem_waddr;
	logic [IDX_W-1:0]               mem_raddr;

	pgsa_pkg::div_req_t             div_req;
	pgsa_pkg::div_rsp_t             div_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Pool in use is the register clamped to the bitmap size
	always_comb begin
		if (32'(total_q) > 32'(pgsa_pkg::MAX_PRBS)) begin
			pool = CNT_W'(pgsa_pkg::MAX_PRBS);
		end else begin
			pool = CNT_W'(total_q);
		end
	end

	// Byte demand and bytes per block for the divider
	always_comb begin
		in_bits = pgsa_pkg::bits_per_block(mcs);
		in_bpb  = in_bits[pgsa_pkg::BITS_W-1:3];
		demand  = (demand_bytes == '0) ? pgsa_pkg::EMPTY_DEMAND_BYTES : demand_bytes;
		div_req.start    = in_beat && (command == pgsa_pkg::CMD_SIZE);
		div_req.divisor  = in_bpb;
		div_req.dividend = pgsa_pkg::DIVIDEND_W'(demand)
			+ pgsa_pkg::DIVIDEND_W'(in_bpb) - pgsa_pkg::DIVIDEND_W'(1);
	end

	pgsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Scan helpers
	always_comb begin
		scan_start = idx_q + CNT_W'(1) - CNT_W'(n_q);
		tbs_full   = prod_s1[pgsa_pkg::PROD_W-1:3];
	end

	// Bitmap port control: clear or mark at the current block, read one block ahead
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_MARK);
		mem_wdata = (state_q == ST_MARK);
		mem_waddr = idx_q[IDX_W-1:0];
		if (state_q == ST_SCAN) begin
			mem_raddr = idx_q[IDX_W-1:0] + IDX_W'(1);
		end else begin
			mem_raddr = '0;
		end
	end

	// Bitmap store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			busy_mem[mem_waddr] <= mem_wdata;
		end
		busy_rd_q <= busy_mem[mem_raddr];
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			total_q       <= pgsa_pkg::RESET_TOTAL_PRBS;
			clr_reply_q   <= 1'b0;
			bits_q        <= '0;
			n_q           <= '0;
			run_q         <= '0;
			idx_q         <= '0;
			start_q       <= '0;
			prod_s1       <= '0;
			res_granted_q <= 1'b0;
			res_start_q   <= '0;
			res_count_q   <= '0;
			res_tbs_q     <= '0;
			out_valid_q   <= 1'b0;
			granted_q     <= 1'b0;
			run_start_q   <= '0;
			grant_prbs_q  <= '0;
			tbs_bytes_q   <= '0;
		end else begin
			// hold the pool size
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end

			// raise the output beat on load, drop it once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						bits_q        <= in_bits;
						n_q           <= prb_count;
						res_granted_q <= 1'b0;
						res_start_q   <= '0;
						res_count_q   <= '0;
						res_tbs_q     <= '0;
						case (command)
							pgsa_pkg::CMD_CLEAR: begin
								idx_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end
							pgsa_pkg::CMD_SIZE:  state_q <= ST_DIV;
							pgsa_pkg::CMD_FIXED: state_q <= ST_CHECK;
							default:             state_q <= ST_DONE;
						endcase
					end
				end

				// free every block of the bitmap, one per cycle
				ST_CLEAR: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == CNT_W'(pgsa_pkg::MAX_PRBS - 1)) begin
						if (clr_reply_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				// cap the block count at the pool
				ST_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient > pgsa_pkg::DIVIDEND_W'(pool)) begin
							n_q <= COUNT_W'(pool);
						end else begin
							n_q <= COUNT_W'(div_rsp.quotient);
						end
						state_q <= ST_CHECK;
					end
				end

				// reject empty or oversized requests
				ST_CHECK: begin
					idx_q <= '0;
					run_q <= '0;
					if ((n_q == '0) || (32'(n_q) > 32'(pool))) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end

				// advance one block per cycle looking for a free run
				ST_SCAN: begin
					if (idx_q == pool) begin
						state_q <= ST_DONE;
					end else if (busy_rd_q) begin
						run_q <= '0;
						idx_q <= idx_q + CNT_W'(1);
					end else if (({1'b0, run_q} + 9'd1) == {1'b0, n_q}) begin
						start_q <= IDX_W'(scan_start);
						idx_q   <= scan_start;
						run_q   <= n_q;
						state_q <= ST_MARK;
					end else begin
						run_q <= run_q + COUNT_W'(1);
						idx_q <= idx_q + CNT_W'(1);
					end
				end

				// mark the run busy, one block per cycle
				ST_MARK: begin
					idx_q <= idx_q + CNT_W'(1);
					run_q <= run_q - COUNT_W'(1);
					if (run_q == COUNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					prod_s1 <= pgsa_pkg::PROD_W'(bits_q) * pgsa_pkg::PROD_W'(n_q);
					state_q <= ST_TBS;
				end

				// saturate the transport size
				ST_TBS: begin
					res_granted_q <= 1'b1;
					res_start_q   <= pgsa_pkg::START_W'(start_q);
					res_count_q   <= n_q;
					if (tbs_full > (pgsa_pkg::PROD_W-3)'(pgsa_pkg::TBS_MAX)) begin
						res_tbs_q <= pgsa_pkg::TBS_MAX;
					end else begin
						res_tbs_q <= pgsa_pkg::TBS_W'(tbs_full);
					end
					state_q <= ST_DONE;
				end

				// load the output register once it is free
				ST_DONE: begin
					if (load_out) begin
						granted_q    <= res_granted_q;
						run_start_q  <= res_start_q;
						grant_prbs_q <= res_count_q;
						tbs_bytes_q  <= res_tbs_q;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign run_start  = run_start_q;
	assign grant_prbs = grant_prbs_q;
	assign tbs_bytes  = tbs_bytes_q;

endmodule

// File: test/tb_prb_grant_sizing_allocator.sv
// Self-checking testbench for the grant sizing allocator against a bitmap predictor.
module tb_prb_grant_sizing_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	// The package names no code for the spare command value
	localparam pgsa_pkg::cmd_t CMD_UNUSED = 2'd3;

	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES   = 300;
	localparam int unsigned PHASES         = 10;
	localparam int unsigned PHASE_ITEMS    = 145;

	// Pool sizes per phase; the entry of phase 6 is replaced by a random size
	localparam logic [pgsa_pkg::CFG_W-1:0] POOL_PLAN [PHASES] =
		'{8'd128, 8'd1, 8'd77, 8'd0, 8'd255, 8'd6, 8'd100, 8'd100, 8'd3, 8'd128};

	typedef struct {
		logic                          granted;
		logic [pgsa_pkg::START_W-1:0]  start;
		logic [pgsa_pkg::COUNT_W-1:0]  blocks;
		logic [pgsa_pkg::TBS_W-1:0]    tbs;
	} grant_t;

	// Bitmap predictor and queue of grants still owed by the block
	class grant_ledger;
		int unsigned                  anchor_mcs[6];
		int unsigned                  anchor_bits[6];
		int unsigned                  pool_reg;
		bit [pgsa_pkg::MAX_PRBS-1:0]  busy;
		grant_t                       queued[$];
		int unsigned                  failures;

		function new();
			anchor_mcs  = '{0, 5, 10, 15, 20, 28};
			anchor_bits = '{16, 64, 120, 176, 272, 456};
			pool_reg    = pgsa_pkg::RESET_TOTAL_PRBS;
			busy        = '0;
			failures    = 0;
		endfunction

		function void set_pool_size(int unsigned value);
			pool_reg = value;
		endfunction

		function int unsigned pool_blocks();
			return (pool_reg < pgsa_pkg::MAX_PRBS) ? pool_reg : pgsa_pkg::MAX_PRBS;
		endfunction

		function int unsigned pending();
			return queued.size();
		endfunction

		// Interpolate bits per block between the two anchors around the MCS
		function int unsigned bits_for_mcs(int unsigned m);
			int unsigned seg;
			seg = 0;
			if (m <= anchor_mcs[0])
				return anchor_bits[0];
			if (m >= anchor_mcs[5])
				return anchor_bits[5];
			while (seg < 4 && anchor_mcs[seg + 1] <= m)
				seg++;
			return anchor_bits[seg] + (anchor_bits[seg + 1] - anchor_bits[seg]) *
				(m - anchor_mcs[seg]) / (anchor_mcs[seg + 1] - anchor_mcs[seg]);
		endfunction

		// Work out the grant owed for one accepted command beat
		function void note_command(pgsa_pkg::cmd_t cmd, int unsigned m, int unsigned req,
				int unsigned cnt);
			grant_t      g;
			int unsigned pool, want, bpb, run, first, tbs, i;
			bit          placed;
			g = '{granted: 1'b0, start: '0, blocks: '0, tbs: '0};
			pool = pool_blocks();
			want = 0;
			run = 0;
			first = 0;
			placed = 1'b0;
			if (cmd == pgsa_pkg::CMD_CLEAR) begin
				busy = '0;
			end else if (cmd == pgsa_pkg::CMD_SIZE) begin
				bpb = bits_for_mcs(m) / 8;
				if (bpb == 0)
					bpb = 1;
				if (req == 0)
					req = pgsa_pkg::EMPTY_DEMAND_BYTES;
				want = (req + bpb - 1) / bpb;
				if (want > pool)
					want = pool;
			end else if (cmd == pgsa_pkg::CMD_FIXED) begin
				want = cnt;
			end
			// First-fit scan over the blocks of the current pool
			if (want != 0 && want <= pool) begin
				for (i = 0; i < pool && !placed; i++) begin
					if (busy[i]) begin
						run = 0;
					end else begin
						run++;
						if (run >= want) begin
							first = i + 1 - want;
							placed = 1'b1;
						end
					end
				end
			end
			// Mark the run and size the transport block
			if (placed) begin
				for (i = first; i < first + want; i++)
					busy[i] = 1'b1;
				tbs = bits_for_mcs(m) * want / 8;
				if (tbs > pgsa_pkg::TBS_MAX)
					tbs = pgsa_pkg::TBS_MAX;
				g.granted = 1'b1;
				g.start   = pgsa_pkg::START_W'(first);
				g.blocks  = pgsa_pkg::COUNT_W'(want);
				g.tbs     = pgsa_pkg::TBS_W'(tbs);
			end
			queued.insert(queued.size(), g);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				failures++;
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// Compare one grant beat with the oldest owed grant
		function void check_grant(logic g, logic [pgsa_pkg::START_W-1:0] s,
				logic [pgsa_pkg::COUNT_W-1:0] n, logic [pgsa_pkg::TBS_W-1:0] t);
			grant_t w;
			if (queued.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected grant beat, expected none, got %0d/%0d/%0d/%0d",
					$time, g, s, n, t);
				return;
			end
			w = queued.pop_front();
			compare_field("granted", w.granted, g);
			compare_field("run_start", w.start, s);
			compare_field("grant_prbs", w.blocks, n);
			compare_field("tbs_bytes", w.tbs, t);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pgsa_pkg::CFG_W-1:0]    cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [pgsa_pkg::CMD_W-1:0]    command;
	logic [pgsa_pkg::MCS_W-1:0]    mcs;
	logic [pgsa_pkg::REQ_W-1:0]    demand_bytes;
	logic [pgsa_pkg::COUNT_W-1:0]  prb_count;
	logic                          out_valid;
	logic                          out_ready;
	logic                          granted;
	logic [pgsa_pkg::START_W-1:0]  run_start;
	logic [pgsa_pkg::COUNT_W-1:0]  grant_prbs;
	logic [pgsa_pkg::TBS_W-1:0]    tbs_bytes;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	grant_ledger ledger;

	prb_grant_sizing_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.mcs          (mcs),
		.demand_bytes (demand_bytes),
		.prb_count    (prb_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.run_start    (run_start),
		.grant_prbs   (grant_prbs),
		.tbs_bytes    (tbs_bytes)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the grant side at random
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Check every grant beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_grant(granted, run_start, grant_prbs, tbs_bytes);
	end

	// End the run when no channel has moved a beat for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** prb_grant_sizing_allocator: FAILED **");
		$finish;
	end

	// Present one command beat after a random gap; returns at the next falling edge
	task automatic send_command(input pgsa_pkg::cmd_t cmd,
			input logic [pgsa_pkg::MCS_W-1:0] m, input logic [pgsa_pkg::REQ_W-1:0] req,
			input logic [pgsa_pkg::COUNT_W-1:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		command      = cmd;
		mcs          = m;
		demand_bytes = req;
		prb_count    = cnt;
		do
			@(posedge clk);
		while (!in_ready);
		ledger.note_command(cmd, m, req, cnt);
		@(negedge clk);
	endtask

	// Mostly well-formed requests sized to the pool, with clears and broken fields mixed in
	task automatic send_random_command();
		pgsa_pkg::cmd_t                cmd;
		logic [pgsa_pkg::MCS_W-1:0]    m;
		logic [pgsa_pkg::REQ_W-1:0]    req;
		logic [pgsa_pkg::COUNT_W-1:0]  cnt;
		int unsigned                   pick, span;
		span = (ledger.pool_blocks() == 0) ? 1 : ledger.pool_blocks();
		m    = pgsa_pkg::MCS_W'($urandom_range(31));
		req  = pgsa_pkg::REQ_W'($urandom);
		cnt  = pgsa_pkg::COUNT_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			cmd = pgsa_pkg::CMD_CLEAR;
		end else if (pick < 12) begin
			cmd = CMD_UNUSED;
		end else if (pick < 56) begin
			cmd = pgsa_pkg::CMD_SIZE;
			case ($urandom_range(9))
				0: req = '0;
				1: req = pgsa_pkg::REQ_W'($urandom);
				default: req = pgsa_pkg::REQ_W'($urandom_range(1, span * 12));
			endcase
		end else begin
			cmd = pgsa_pkg::CMD_FIXED;
			case ($urandom_range(9))
				0: cnt = '0;
				1: cnt = pgsa_pkg::COUNT_W'($urandom);
				2: cnt = pgsa_pkg::COUNT_W'(span + $urandom_range(1, 20));
				default: cnt = pgsa_pkg::COUNT_W'($urandom_range(1, (span + 3) / 4));
			endcase
		end
		send_command(cmd, m, req, cnt);
	endtask

	// Write the pool size once every owed grant has come back
	task automatic write_pool_size(input logic [pgsa_pkg::CFG_W-1:0] value);
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		ledger.set_pool_size(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		ledger        = new();
		send_idle_pct = 27;
		recv_idle_pct = 52;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = pgsa_pkg::CMD_CLEAR;
		mcs           = '0;
		demand_bytes  = '0;
		prb_count     = '0;
		out_ready     = 1'b0;

		// Hold reset, release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset pool of 100, field extremes, failures and each command
		send_command(pgsa_pkg::CMD_CLEAR, 5'd0, 22'd0, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd0, 22'd0, 8'd0);        // empty demand is 100 bytes
		send_command(pgsa_pkg::CMD_SIZE, 5'd31, 22'd1, 8'd255);     // top anchor above MCS 28
		send_command(pgsa_pkg::CMD_FIXED, 5'd7, 22'h3FFFFF, 8'd0);  // zero count fails
		send_command(pgsa_pkg::CMD_FIXED, 5'd7, 22'd0, 8'd255);     // count beyond pool
		send_command(pgsa_pkg::CMD_FIXED, 5'd7, 22'd0, 8'd128);
		send_command(pgsa_pkg::CMD_FIXED, 5'd5, 22'd0, 8'd49);      // fills the pool exactly
		send_command(pgsa_pkg::CMD_FIXED, 5'd10, 22'd0, 8'd1);      // no free run left
		send_command(CMD_UNUSED, 5'd31, 22'h3FFFFF, 8'd255);
		send_command(pgsa_pkg::CMD_CLEAR, 5'd31, 22'h3FFFFF, 8'd255);
		send_command(pgsa_pkg::CMD_SIZE, 5'd28, 22'h3FFFFF, 8'd0);  // count capped at the pool
		send_command(pgsa_pkg::CMD_SIZE, 5'd20, 22'd1, 8'd0);
		send_command(pgsa_pkg::CMD_CLEAR, 5'd0, 22'd0, 8'd0);
		send_command(pgsa_pkg::CMD_FIXED, 5'd27, 22'd0, 8'd100);
		send_command(pgsa_pkg::CMD_CLEAR, 5'd0, 22'd0, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd5, 22'd8, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd10, 22'd16, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd15, 22'd22, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd1, 22'd3, 8'd0);
		send_command(pgsa_pkg::CMD_SIZE, 5'd13, 22'd100, 8'd0);
		send_command(pgsa_pkg::CMD_FIXED, 5'd17, 22'd0, 8'd10);
		send_command(pgsa_pkg::CMD_FIXED, 5'd9, 22'd0, 8'd33);
		send_command(pgsa_pkg::CMD_SIZE, 5'd24, 22'd2000, 8'd0);

		// Random phases over several pool sizes; the bitmap carries across each write
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p < 3) ? 27 : (p < 6) ? 52 : 0;
			recv_idle_pct = (p < 3) ? 52 : (p < 6) ? 27 : 0;
			write_pool_size((p == 6) ? pgsa_pkg::CFG_W'($urandom_range(1, 128)) : POOL_PLAN[p]);
			repeat (PHASE_ITEMS) send_random_command();
		end

		// Drain and let the block settle
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.failures == 0 && ledger.pending() == 0)
			$display("** prb_grant_sizing_allocator: PASSED **");
		else
			$display("** prb_grant_sizing_allocator: FAILED **");
		$finish;
	end

endmodule
